### hw/rtl/two_type_bracket_unranker_macros.svh
// Assertion macros used by the bracket unranker checker
`ifndef TWO_TYPE_BRACKET_UNRANKER_MACROS_SVH
`define TWO_TYPE_BRACKET_UNRANKER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define TBU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbu: implication check failed");

// Next-cycle implication, clocked on i_clk, off during reset
`define TBU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbu: next-cycle check failed");

`endif

### hw/rtl/tbu_pkg.sv
// Shared widths and symbol codes of the two-type bracket unranker
`default_nettype none

package tbu_pkg;

    localparam int CFG_W  = 5;   // pair count write data
    localparam int RANK_W = 63;  // input rank
    localparam int CNT_W  = 64;  // path count table entry
    localparam int SYM_W  = 2;   // output symbol

    typedef enum logic [SYM_W-1:0] {
        SYM_OPEN_ROUND   = 2'd0,
        SYM_CLOSE_ROUND  = 2'd1,
        SYM_OPEN_SQUARE  = 2'd2,
        SYM_CLOSE_SQUARE = 2'd3
    } t_symbol;

endpackage

`default_nettype wire

### hw/rtl/two_type_bracket_unranker.sv
// Two-type bracket unranker: rank in, balanced ( ) [ ] sequence out
//
//  channel  | signals                                   | dir | moves
//  ---------+-------------------------------------------+-----+-----------------------------
//  rank     | i_in_valid o_in_ready i_rank              | in  | one rank per request
//  symbols  | o_out_valid i_out_ready o_symbol o_last   | out | one symbol per request,
//           | o_rank_error                              |     | 2*pair_count per rank, 1 if out of range
//  config   | i_cfg_valid o_cfg_ready i_cfg_pair_count  | in  | pair count write
//
//  A rank goes through the range check (total read, total, check), then per symbol
//  through two reads of the count table on its single read port, up to three
//  compare/subtract steps and an emit step, which waits while the output register
//  is full and i_out_ready is low.
//  After reset the count table is filled row by row, row 0 first and then each
//  row from the one below it; no rank is taken until then, pair count writes are
//  taken at any time.
//  A finished symbol sits in the output register while the next one is built.
`default_nettype none

module two_type_bracket_unranker #(
    parameter int MAX_PAIRS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // rank channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [tbu_pkg::RANK_W-1:0] i_rank,
    // symbol channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [tbu_pkg::SYM_W-1:0]       o_symbol,
    output logic                            o_last,
    output logic                            o_rank_error,
    // configuration channel
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tbu_pkg::CFG_W-1:0]  i_cfg_pair_count
);
    import tbu_pkg::*;

    localparam int TDIM = 2 * MAX_PAIRS + 1;             // rows and columns of table
    localparam int AW   = $clog2(TDIM * TDIM);           // table address
    localparam int LW   = $clog2(TDIM + 1);              // lengths, heights, columns
    localparam int BW   = $clog2(MAX_PAIRS + 2);         // balance
    localparam int SW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;  // stack index
    localparam int PCW  = $clog2(MAX_PAIRS + 1);         // pair count, shift amounts

    typedef enum logic [3:0] {
        S_INIT0, S_BUILD, S_BTAIL, S_IDLE, S_TOT_RD, S_TOT, S_CHK,
        S_UP_RD, S_DN_RD, S_CMP1, S_CMP2, S_CMP3, S_EMIT
    } t_state;

    // flat address of table entry [row][col]
    function automatic logic [AW-1:0] row_addr(input logic [LW-1:0] row,
                                               input logic [LW-1:0] col);
        return AW'(row) * AW'(TDIM) + AW'(col);
    endfunction

    t_state              r_state;
    logic [PCW-1:0]      r_pair_count;

    // table build
    logic [LW-1:0]       r_blen;
    logic [LW-1:0]       r_bidx;
    logic [LW-1:0]       r_bcol;
    logic                r_bpend;
    logic [CNT_W-1:0]    r_d1;
    logic [CNT_W-1:0]    r_d2;

    // walk
    logic [RANK_W-1:0]   r_rr;
    logic [LW-1:0]       r_pos;
    logic [BW-1:0]       r_bal;
    logic                r_stack [MAX_PAIRS];
    logic [PCW-1:0]      r_sh_up;
    logic [PCW-1:0]      r_sh_dn;
    logic                r_ok_up;
    logic                r_ok_dn;
    logic [CNT_W-1:0]    r_w_up;
    logic [CNT_W-1:0]    r_w_dn;
    t_symbol             r_sym;
    logic                r_err;

    // output register
    logic                r_out_valid;
    t_symbol             r_out_sym;
    logic                r_out_last;
    logic                r_out_err;

    // count table memory
    logic [CNT_W-1:0]    mem_table [TDIM * TDIM];
    logic [CNT_W-1:0]    r_rdata;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [CNT_W-1:0]    w_wdata;
    logic [AW-1:0]       w_raddr;

    logic [LW-1:0]       w_len;
    logic [LW-1:0]       w_rem;
    logic [LW-1:0]       w_h_up;
    logic [LW-1:0]       w_h_dn;
    logic                w_can_open;
    logic                w_top_round;
    logic                w_last_pos;
    logic [CNT_W-1:0]    w_bdata;
    logic                w_out_free;
    logic                w_is_open;
    logic [CNT_W-1:0]    w_rr_ext;

    // position arithmetic
    assign w_len       = LW'(r_pair_count) << 1;
    assign w_rem       = w_len - r_pos - LW'(1);
    assign w_h_up      = LW'(r_bal) + LW'(1);
    assign w_h_dn      = (r_bal == '0) ? '0 : LW'(r_bal) - LW'(1);
    assign w_can_open  = LW'(r_bal) < LW'(r_pair_count);
    assign w_top_round = (r_bal != '0) && (LW'(r_bal) <= LW'(MAX_PAIRS)) &&
                         !r_stack[SW'(r_bal - BW'(1))];
    assign w_last_pos  = (r_pos + LW'(1)) == w_len;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_is_open   = (r_sym == SYM_OPEN_ROUND) || (r_sym == SYM_OPEN_SQUARE);
    assign w_rr_ext    = CNT_W'(r_rr);

    // column past the right edge reads as zero during the build
    assign w_bdata = (r_bcol == LW'(TDIM)) ? '0 : r_rdata;

    // table write: row 0 first, then each row from the one below it
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        if (r_state == S_INIT0) begin
            w_we    = 1'b1;
            w_waddr = AW'(r_bidx);
            w_wdata = (r_bidx == '0) ? CNT_W'(1) : '0;
        end else if (r_bpend && (r_bcol != '0)) begin
            w_we    = 1'b1;
            w_waddr = row_addr(r_blen, r_bcol - LW'(1));
            w_wdata = r_d2 + w_bdata;
        end
    end

    // table read address
    always_comb begin
        unique case (r_state)
            S_BUILD:  w_raddr = row_addr(r_blen - LW'(1), r_bidx);
            S_TOT_RD: w_raddr = row_addr(w_len, '0);
            S_UP_RD:  w_raddr = row_addr(w_rem, w_h_up);
            S_DN_RD:  w_raddr = row_addr(w_rem, w_h_dn);
            default:  w_raddr = '0;
        endcase
    end

    // count table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_table[w_waddr] <= w_wdata;
        end
        r_rdata <= mem_table[w_raddr];
    end

    // pair count register, saturated to 1..MAX_PAIRS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= PCW'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_pair_count == '0) begin
                r_pair_count <= PCW'(1);
            end else if (i_cfg_pair_count > CFG_W'(MAX_PAIRS)) begin
                r_pair_count <= PCW'(MAX_PAIRS);
            end else begin
                r_pair_count <= PCW'(i_cfg_pair_count);
            end
        end
    end

    // sequencer: table build, range check, symbol walk, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT0;
            r_bidx      <= '0;
            r_blen      <= '0;
            r_bpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the emit state loads the output register itself
            if (i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            // build datapath: slide a three-entry window along the lower row
            r_bpend <= (r_state == S_BUILD);
            r_bcol  <= r_bidx;
            if (r_bpend && (r_state != S_BTAIL)) begin
                r_d2 <= r_d1;
                r_d1 <= w_bdata;
            end

            unique case (r_state)
                S_INIT0: begin
                    if (r_bidx == LW'(TDIM - 1)) begin
                        r_blen  <= LW'(1);
                        r_bidx  <= '0;
                        r_d1    <= '0;
                        r_d2    <= '0;
                        r_state <= S_BUILD;
                    end else begin
                        r_bidx <= r_bidx + LW'(1);
                    end
                end
                S_BUILD: begin
                    if (r_bidx == LW'(TDIM)) begin
                        r_state <= S_BTAIL;
                    end else begin
                        r_bidx <= r_bidx + LW'(1);
                    end
                end
                S_BTAIL: begin
                    if (r_blen == LW'(TDIM - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_blen  <= r_blen + LW'(1);
                        r_bidx  <= '0;
                        r_d1    <= '0;
                        r_d2    <= '0;
                        r_state <= S_BUILD;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rr    <= i_rank;
                        r_pos   <= '0;
                        r_bal   <= '0;
                        r_state <= S_TOT_RD;
                    end
                end
                S_TOT_RD: begin
                    r_state <= S_TOT;
                end
                S_TOT: begin
                    // total count = ballot count times 2^pairs
                    r_w_up  <= r_rdata << r_pair_count;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_rr_ext >= r_w_up) begin
                        r_sym   <= SYM_OPEN_ROUND;
                        r_err   <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_err   <= 1'b0;
                        r_state <= S_UP_RD;
                    end
                end
                S_UP_RD: begin
                    r_sh_up <= PCW'((w_rem - w_h_up) >> 1);
                    r_ok_up <= w_can_open && (w_h_up <= w_rem);
                    r_state <= S_DN_RD;
                end
                S_DN_RD: begin
                    r_w_up  <= r_ok_up ? (r_rdata << r_sh_up) : '0;
                    r_sh_dn <= PCW'((w_rem - w_h_dn) >> 1);
                    r_ok_dn <= w_top_round && (w_h_dn <= w_rem);
                    r_state <= S_CMP1;
                end
                S_CMP1: begin
                    r_w_dn <= r_ok_dn ? (r_rdata << r_sh_dn) : '0;
                    if (r_w_up > w_rr_ext) begin
                        r_sym   <= SYM_OPEN_ROUND;
                        r_state <= S_EMIT;
                    end else begin
                        r_rr    <= RANK_W'(w_rr_ext - r_w_up);
                        r_state <= S_CMP2;
                    end
                end
                S_CMP2: begin
                    if (r_w_dn > w_rr_ext) begin
                        r_sym   <= SYM_CLOSE_ROUND;
                        r_state <= S_EMIT;
                    end else begin
                        r_rr    <= RANK_W'(w_rr_ext - r_w_dn);
                        r_state <= S_CMP3;
                    end
                end
                S_CMP3: begin
                    if (r_w_up > w_rr_ext) begin
                        r_sym <= SYM_OPEN_SQUARE;
                    end else begin
                        r_rr  <= RANK_W'(w_rr_ext - r_w_up);
                        r_sym <= SYM_CLOSE_SQUARE;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sym   <= r_sym;
                        r_out_last  <= r_err || w_last_pos;
                        r_out_err   <= r_err;
                        if (r_err) begin
                            r_state <= S_IDLE;
                        end else begin
                            // push or pop the open bracket type
                            if (w_is_open) begin
                                if (LW'(r_bal) < LW'(MAX_PAIRS)) begin
                                    r_stack[SW'(r_bal)] <= (r_sym == SYM_OPEN_SQUARE);
                                end
                                r_bal <= r_bal + BW'(1);
                            end else begin
                                r_bal <= r_bal - BW'(1);
                            end
                            r_pos   <= r_pos + LW'(1);
                            r_state <= w_last_pos ? S_IDLE : S_UP_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_symbol     = r_out_sym;
    assign o_last       = r_out_last;
    assign o_rank_error = r_out_err;

endmodule

`default_nettype wire

### hw/rtl/tbu_checker.sv
// Port-level checks of the two-type bracket unranker, bound to the top level
`default_nettype none

`include "two_type_bracket_unranker_macros.svh"

module tbu_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [tbu_pkg::SYM_W-1:0]  o_symbol,
    input wire logic                       o_last,
    input wire logic                       o_rank_error
);
    import tbu_pkg::*;

    // an out-of-range rank gives one open-round symbol flagged last
    `TBU_ASSERT_IMP(a_err_single, o_out_valid && o_rank_error, o_last && (o_symbol == SYM_OPEN_ROUND))
    // a taken rank keeps the block busy for at least the next cycle
    `TBU_ASSERT_NXT(a_busy_after_take, i_in_valid && o_in_ready, !o_in_ready)
    // mid-sequence symbols mean the walk is still running
    `TBU_ASSERT_IMP(a_no_take_mid_seq, o_out_valid && !o_last, !o_in_ready)
    // a stalled symbol request holds
    `TBU_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_symbol) && $stable(o_last) && $stable(o_rank_error))

endmodule

bind two_type_bracket_unranker tbu_checker u_tbu_checker (.*);

`default_nettype wire

### verif/tb.sv
// Testbench for the two-type bracket unranker: directed table plus random ranks
`timescale 1ns / 1ps

module tb;
    import tbu_pkg::*;

    localparam int TB_MAX_PAIRS   = 16;
    localparam int TDIM           = 2 * TB_MAX_PAIRS + 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_LIMIT   = 10;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_ERROR,
        CHK_ROUND_PAIR,
        CHK_SQUARE_PAIR
    } t_check;

    typedef struct packed {
        t_symbol symbol;
        logic    last;
        logic    rank_error;
    } t_bracket_out;

    typedef struct packed {
        bit                 set_pairs;
        logic [CFG_W-1:0]   pairs_wr;
        bit                 from_top;   // rank is taken as total count minus rank
        logic [RANK_W-1:0]  rank;
        t_check             check;
    } t_dir_row;

    localparam logic [RANK_W-1:0] RANK_ALL_ONES = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [RANK_W-1:0]   i_rank;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [SYM_W-1:0]    o_symbol;
    logic                o_last;
    logic                o_rank_error;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_pair_count;

    // predictor state
    logic [63:0]         path_tbl [TDIM][TDIM];
    bit                  open_kind [TB_MAX_PAIRS];
    int                  cur_pairs;
    t_bracket_out        bracket_q [$];

    int                  mismatch_count;
    int                  results_seen;
    int                  quiet_left [2];
    int                  idle_cycles;

    // directed rows: reset setting first, then saturation and the count extremes
    t_dir_row dir_rows [24] = '{
        '{1'b0, 5'd0,  1'b0, 63'd0,                     CHK_ROUND_PAIR},
        '{1'b0, 5'd0,  1'b0, 63'd1,                     CHK_SQUARE_PAIR},
        '{1'b0, 5'd0,  1'b0, 63'd2,                     CHK_ERROR},
        '{1'b0, 5'd0,  1'b0, RANK_ALL_ONES,             CHK_ERROR},
        '{1'b1, 5'd0,  1'b1, 63'd0,                     CHK_ERROR},
        '{1'b0, 5'd0,  1'b0, 63'd1,                     CHK_SQUARE_PAIR},
        '{1'b1, 5'd2,  1'b0, 63'd0,                     CHK_PREDICT},
        '{1'b0, 5'd0,  1'b0, 63'd3,                     CHK_PREDICT},
        '{1'b0, 5'd0,  1'b0, 63'd5,                     CHK_PREDICT},
        '{1'b0, 5'd0,  1'b1, 63'd1,                     CHK_PREDICT},
        '{1'b0, 5'd0,  1'b1, 63'd0,                     CHK_ERROR},
        '{1'b1, 5'd3,  1'b0, 63'd17,                    CHK_PREDICT},
        '{1'b1, 5'd31, 1'b0, 63'd0,                     CHK_PREDICT},
        '{1'b0, 5'd0,  1'b1, 63'd1,                     CHK_PREDICT},
        '{1'b0, 5'd0,  1'b1, 63'd0,                     CHK_ERROR},
        '{1'b0, 5'd0,  1'b0, RANK_ALL_ONES,             CHK_ERROR},
        '{1'b0, 5'd0,  1'b0, 63'd12345678901,           CHK_PREDICT},
        '{1'b1, 5'd17, 1'b0, 63'h4000_0000_0000_0000,   CHK_ERROR},
        '{1'b0, 5'd0,  1'b0, 63'h100_0000_0000,         CHK_PREDICT},
        '{1'b1, 5'd15, 1'b1, 63'd1,                     CHK_PREDICT},
        '{1'b0, 5'd0,  1'b0, 63'd999,                   CHK_PREDICT},
        '{1'b1, 5'd1,  1'b0, 63'd0,                     CHK_ROUND_PAIR},
        '{1'b0, 5'd0,  1'b1, 63'd1,                     CHK_SQUARE_PAIR},
        '{1'b1, 5'd8,  1'b0, 63'd0,                     CHK_PREDICT}
    };

    two_type_bracket_unranker #(
        .MAX_PAIRS (TB_MAX_PAIRS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rank           (i_rank),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_symbol         (o_symbol),
        .o_last           (o_last),
        .o_rank_error     (o_rank_error),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_pair_count (i_cfg_pair_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ballot paths down to zero, indexed by remaining length and height
    function automatic void build_paths();
        logic [63:0] v;
        for (int l = 0; l < TDIM; l++) begin
            for (int h = 0; h < TDIM; h++) begin
                path_tbl[l][h] = '0;
            end
        end
        path_tbl[0][0] = 64'd1;
        for (int l = 1; l < TDIM; l++) begin
            for (int h = 0; h < TDIM; h++) begin
                v = '0;
                if (h > 0) v += path_tbl[l-1][h-1];
                if (h + 1 < TDIM) v += path_tbl[l-1][h+1];
                path_tbl[l][h] = v;
            end
        end
    endfunction

    // completions of rem symbols from height h, times the free bracket types
    function automatic logic [63:0] completions(int rem, int h);
        if (h > rem || rem >= TDIM) return '0;
        return path_tbl[rem][h] << ((rem - h) / 2);
    endfunction

    function automatic logic [63:0] seq_total(int p);
        return path_tbl[2*p][0] << p;
    endfunction

    function automatic void expect_symbol(t_symbol s, logic last, logic err);
        t_bracket_out e;
        e.symbol     = s;
        e.last       = last;
        e.rank_error = err;
        bracket_q.push_back(e);
    endfunction

    // walk the positions, passing over lower symbols by subtracting their counts
    function automatic void predict_sequence(logic [RANK_W-1:0] rank);
        int          len;
        int          rem;
        int          bal;
        logic [63:0] left;
        logic [63:0] w;
        t_symbol     s;
        bit          top_round;
        bit          can_open;
        len  = 2 * cur_pairs;
        left = {1'b0, rank};
        if (left >= seq_total(cur_pairs)) begin
            expect_symbol(SYM_OPEN_ROUND, 1'b1, 1'b1);
            return;
        end
        bal = 0;
        for (int pos = 0; pos < len; pos++) begin
            rem       = len - pos - 1;
            top_round = bal > 0 && bal <= TB_MAX_PAIRS && open_kind[bal-1] == 1'b0;
            can_open  = bal + 1 <= cur_pairs;
            w = can_open ? completions(rem, bal + 1) : '0;
            if (w > left) begin
                s = SYM_OPEN_ROUND;
            end else begin
                left -= w;
                w = top_round ? completions(rem, bal - 1) : '0;
                if (w > left) begin
                    s = SYM_CLOSE_ROUND;
                end else begin
                    left -= w;
                    w = can_open ? completions(rem, bal + 1) : '0;
                    if (w > left) begin
                        s = SYM_OPEN_SQUARE;
                    end else begin
                        left -= w;
                        s = SYM_CLOSE_SQUARE;
                    end
                end
            end
            if (s == SYM_OPEN_ROUND || s == SYM_OPEN_SQUARE) begin
                if (bal < TB_MAX_PAIRS) open_kind[bal] = (s == SYM_OPEN_SQUARE);
                bal = (bal + 1) & 31;
            end else begin
                bal = (bal - 1) & 31;
            end
            expect_symbol(s, pos + 1 == len, 1'b0);
        end
    endfunction

    // idle lengths: mostly short, a few long, with quiet stretches of none
    function automatic int pick_gap(int side);
        int r;
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly in-range ranks, with the range edges and full-width values mixed in
    function automatic logic [RANK_W-1:0] pick_rank(int p);
        logic [63:0] total;
        logic [63:0] raw;
        int          r;
        total = seq_total(p);
        raw   = {$urandom, $urandom};
        r     = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 16) return RANK_W'(total - 64'd1);
        if (r < 22) return RANK_W'(total + 64'($urandom_range(0, 3)));
        if (r < 30) return raw[RANK_W-1:0];
        return RANK_W'(raw % total);
    endfunction

    // one rank request; expectations are queued at the accepting edge
    task automatic send_rank(logic [RANK_W-1:0] rank, t_check chk);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rank     <= rank;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        case (chk)
            CHK_ERROR: expect_symbol(SYM_OPEN_ROUND, 1'b1, 1'b1);
            CHK_ROUND_PAIR: begin
                expect_symbol(SYM_OPEN_ROUND, 1'b0, 1'b0);
                expect_symbol(SYM_CLOSE_ROUND, 1'b1, 1'b0);
            end
            CHK_SQUARE_PAIR: begin
                expect_symbol(SYM_OPEN_SQUARE, 1'b0, 1'b0);
                expect_symbol(SYM_CLOSE_SQUARE, 1'b1, 1'b0);
            end
            default: predict_sequence(rank);
        endcase
        gap = pick_gap(0);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop offering and wait for every queued symbol; returns on a falling edge
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (bracket_q.size() != 0) @(negedge i_clk);
    endtask

    // pair count write, only with the block idle
    task automatic write_pairs(logic [CFG_W-1:0] value);
        wait_quiet();
        i_cfg_valid      <= 1'b1;
        i_cfg_pair_count <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (value < 1) cur_pairs = 1;
        else if (value > TB_MAX_PAIRS) cur_pairs = TB_MAX_PAIRS;
        else cur_pairs = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls plus one long hold-off while ranks keep coming
    initial begin
        int  stall_left;
        int  hold_left;
        bit  held_once;
        stall_left  = 0;
        hold_left   = 0;
        held_once   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (!held_once && results_seen >= 400 && i_in_valid) begin
                held_once = 1'b1;
                hold_left = HOLDOFF_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap(1);
            end
        end
    end

    // symbol checker
    always @(posedge i_clk) begin
        t_bracket_out want;
        t_bracket_out got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            results_seen++;
            got.symbol     = t_symbol'(o_symbol);
            got.last       = o_last;
            got.rank_error = o_rank_error;
            if (bracket_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected symbol=%0d last=%0d err=%0d", $realtime,
                             got.symbol, got.last, got.rank_error);
            end else begin
                want = bracket_q.pop_front();
                if (got.symbol !== want.symbol || got.last !== want.last ||
                    got.rank_error !== want.rank_error) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: expected symbol=%0d last=%0d err=%0d, got %0d %0d %0d",
                                 $realtime, want.symbol, want.last, want.rank_error,
                                 got.symbol, got.last, got.rank_error);
                end
            end
        end
    end

    // watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [RANK_W-1:0] rank;
        logic [CFG_W-1:0]  pairs_raw;
        mismatch_count   = 0;
        results_seen     = 0;
        idle_cycles      = 0;
        quiet_left[0]    = 0;
        quiet_left[1]    = 0;
        cur_pairs        = 1;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_rank           = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_pair_count = '0;
        for (int k = 0; k < TB_MAX_PAIRS; k++) open_kind[k] = 1'b0;
        build_paths();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_pairs) write_pairs(dir_rows[i].pairs_wr);
            rank = dir_rows[i].from_top ?
                   RANK_W'(seq_total(cur_pairs) - {1'b0, dir_rows[i].rank}) :
                   dir_rows[i].rank;
            send_rank(rank, dir_rows[i].check);
        end

        // random phases, one pair count each; the first and last are the extremes
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 0) pairs_raw = 5'd16;
            else if (phase == 9) pairs_raw = 5'd1;
            else pairs_raw = CFG_W'($urandom_range(0, 31));
            write_pairs(pairs_raw);
            for (int k = 0; k < 26; k++) begin
                // odd phases pause the sender midway until all symbols are back
                if (k == 13 && phase % 2 == 1) wait_quiet();
                send_rank(pick_rank(cur_pairs), CHK_PREDICT);
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && bracket_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tbu_pkg.sv
hw/rtl/two_type_bracket_unranker.sv
hw/rtl/tbu_checker.sv
verif/tb.sv
